>>> rtl/arp_pkg.sv
// ----------------------------------------------------------------------------
// arp_pkg
// Types and constants shared by the address cache controller, datapath
// and top level.
// ----------------------------------------------------------------------------
`default_nettype none

package arp_pkg;

    localparam int IP_W        = 32;
    localparam int MAC_W       = 48;
    localparam int EXP_W       = 16;
    localparam int REQ_W       = 2;
    localparam int CODE_W      = 3;
    localparam int IN_TDATA_W  = 2 * IP_W + MAC_W;
    localparam int OUT_TDATA_W = MAC_W;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 32;

    // request kinds
    localparam logic [REQ_W-1:0] REQ_LOOKUP = 2'd0;
    localparam logic [REQ_W-1:0] REQ_MERGE  = 2'd1;
    localparam logic [REQ_W-1:0] REQ_REPLY  = 2'd2;

    // configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_OWN_IP    = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_EXP_REPLY = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_EXP_MERGE = 2'd2;

    typedef enum logic [CODE_W-1:0] {
        RC_HIT      = 3'd0,
        RC_MISS     = 3'd1,
        RC_INSERTED = 3'd2,
        RC_FULL     = 3'd3,
        RC_IGNORED  = 3'd4
    } result_code_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DECODE,
        ST_SCAN,
        ST_FINISH
    } ctrl_state_t;

    typedef struct packed {
        logic [IP_W-1:0]  own_ip;
        logic [EXP_W-1:0] expire_on_reply;
        logic [EXP_W-1:0] expire_on_merge;
    } cfg_t;

    typedef struct packed {
        logic         load;
        logic         step;
        logic         refresh;
        logic         insert;
        logic         set_result;
        result_code_t result_code;
    } cmd_t;

    typedef struct packed {
        logic ignore;
        logic match;
        logic last;
        logic hit_found;
        logic free_found;
        logic is_lookup;
        logic out_busy;
    } status_t;

endpackage

`default_nettype wire

>>> rtl/arp_ctrl.sv
// ----------------------------------------------------------------------------
// arp_ctrl
// Sequencer for the address cache: accepts an item, walks the slot search
// and picks the update and result code once it ends; ignored items skip it.
// ----------------------------------------------------------------------------
`default_nettype none

module arp_ctrl
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire arp_pkg::status_t status,
    output arp_pkg::cmd_t         cmd
);

    arp_pkg::ctrl_state_t state_reg;
    arp_pkg::ctrl_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= arp_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            arp_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = arp_pkg::ST_DECODE;
                end
            end
            arp_pkg::ST_DECODE:
            begin
                if (!status.ignore)
                begin
                    state_next = arp_pkg::ST_SCAN;
                end
                else if (!status.out_busy)
                begin
                    state_next = arp_pkg::ST_IDLE;
                end
            end
            arp_pkg::ST_SCAN:
            begin
                if (status.match || status.last)
                begin
                    state_next = arp_pkg::ST_FINISH;
                end
            end
            arp_pkg::ST_FINISH:
            begin
                if (!status.out_busy)
                begin
                    state_next = arp_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = arp_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_ready        = 1'b0;
        cmd             = '0;
        cmd.result_code = arp_pkg::RC_IGNORED;
        case (state_reg)
            arp_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            arp_pkg::ST_DECODE:
            begin
                if (status.ignore && !status.out_busy)
                begin
                    cmd.set_result  = 1'b1;
                    cmd.result_code = arp_pkg::RC_IGNORED;
                end
            end
            arp_pkg::ST_SCAN:
            begin
                cmd.step = 1'b1;
            end
            arp_pkg::ST_FINISH:
            begin
                if (!status.out_busy)
                begin
                    cmd.set_result = 1'b1;
                    if (status.is_lookup)
                    begin
                        cmd.result_code = status.hit_found ? arp_pkg::RC_HIT
                                                           : arp_pkg::RC_MISS;
                    end
                    else if (status.hit_found)
                    begin
                        cmd.refresh     = 1'b1;
                        cmd.result_code = arp_pkg::RC_HIT;
                    end
                    else if (status.free_found)
                    begin
                        cmd.insert      = 1'b1;
                        cmd.result_code = arp_pkg::RC_INSERTED;
                    end
                    else
                    begin
                        cmd.result_code = arp_pkg::RC_FULL;
                    end
                end
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

endmodule

`default_nettype wire

>>> rtl/arp_dpath.sv
// ----------------------------------------------------------------------------
// arp_dpath
// Slot storage, request registers, sequential slot search and the
// registered result stage of the address cache.
// ----------------------------------------------------------------------------
`default_nettype none

module arp_dpath
#(
    parameter int ENTRIES = 16
)
(
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire arp_pkg::cfg_t                      cfg,
    input  wire logic [arp_pkg::IN_TDATA_W-1:0]     in_tdata,
    input  wire logic [arp_pkg::REQ_W-1:0]          in_tuser,
    input  wire arp_pkg::cmd_t                      cmd,
    output arp_pkg::status_t                        status,
    input  wire logic                               out_ready,
    output logic                                    out_valid,
    output logic [arp_pkg::OUT_TDATA_W-1:0]         out_tdata,
    output logic [arp_pkg::CODE_W-1:0]              out_tuser
);

    localparam int IDXW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam logic [IDXW-1:0] LAST_IDX = IDXW'(ENTRIES - 1);

    // slot storage
    logic [ENTRIES-1:0]            valid_reg;
    logic [ENTRIES-1:0]            valid_next;
    logic [arp_pkg::IP_W-1:0]      ip_mem  [ENTRIES];
    logic [arp_pkg::MAC_W-1:0]     mac_mem [ENTRIES];
    logic [arp_pkg::EXP_W-1:0]     exp_mem [ENTRIES];

    // request held for the whole search
    logic [arp_pkg::REQ_W-1:0]     req_type_reg;
    logic [arp_pkg::IP_W-1:0]      req_ip_reg;
    logic [arp_pkg::MAC_W-1:0]     req_mac_reg;
    logic [arp_pkg::IP_W-1:0]      req_target_reg;

    // search control
    logic [IDXW-1:0]               issue_idx_reg;
    logic [IDXW-1:0]               issue_idx_next;
    logic                          issue_done_reg;
    logic                          issue_done_next;
    logic                          rd_vld_reg;
    logic                          rd_vld_next;
    logic [IDXW-1:0]               rd_idx_reg;
    logic                          hit_found_reg;
    logic                          hit_found_next;
    logic                          free_found_reg;
    logic                          free_found_next;
    logic                          out_valid_reg;
    logic                          out_valid_next;

    // search payload
    logic [arp_pkg::IP_W-1:0]      ip_rd_reg;
    logic [arp_pkg::MAC_W-1:0]     mac_rd_reg;
    logic [arp_pkg::EXP_W-1:0]     exp_rd_reg;
    logic [IDXW-1:0]               hit_idx_reg;
    logic [arp_pkg::MAC_W-1:0]     hit_mac_reg;
    logic [arp_pkg::EXP_W-1:0]     hit_exp_reg;
    logic [IDXW-1:0]               free_idx_reg;
    logic [arp_pkg::CODE_W-1:0]    out_code_reg;
    logic [arp_pkg::MAC_W-1:0]     out_mac_reg;

    logic                          rd_en;
    logic                          match;
    logic                          capture_hit;
    logic                          capture_free;
    logic                          exp_wr_en;
    logic [IDXW-1:0]               exp_wr_addr;
    logic [arp_pkg::EXP_W-1:0]     timeout;

    assign rd_en   = cmd.step && !issue_done_reg;
    assign match   = rd_vld_reg && valid_reg[rd_idx_reg] && (ip_rd_reg == req_ip_reg);
    assign timeout = (req_type_reg == arp_pkg::REQ_MERGE) ? cfg.expire_on_merge
                                                          : cfg.expire_on_reply;

    assign capture_hit  = cmd.step && match;
    assign capture_free = cmd.step && rd_vld_reg && !valid_reg[rd_idx_reg]
                          && !free_found_reg;

    // a refresh only ever raises the expire value
    assign exp_wr_en   = cmd.insert || (cmd.refresh && (hit_exp_reg < timeout));
    assign exp_wr_addr = cmd.insert ? free_idx_reg : hit_idx_reg;

    always_comb
    begin
        status.match      = match;
        status.last       = rd_vld_reg && (rd_idx_reg == LAST_IDX);
        status.hit_found  = hit_found_reg;
        status.free_found = free_found_reg;
        status.is_lookup  = (req_type_reg == arp_pkg::REQ_LOOKUP);
        status.out_busy   = out_valid_reg && !out_ready;
        case (req_type_reg) inside
            arp_pkg::REQ_LOOKUP, arp_pkg::REQ_MERGE: status.ignore = 1'b0;
            arp_pkg::REQ_REPLY: status.ignore = (req_target_reg != cfg.own_ip);
            default:            status.ignore = 1'b1;
        endcase
    end

    always_comb
    begin
        valid_next      = valid_reg;
        issue_idx_next  = issue_idx_reg;
        issue_done_next = issue_done_reg;
        rd_vld_next     = 1'b0;
        hit_found_next  = hit_found_reg;
        free_found_next = free_found_reg;
        out_valid_next  = out_valid_reg;

        if (cmd.insert)
        begin
            valid_next[free_idx_reg] = 1'b1;
        end

        if (cmd.load)
        begin
            issue_idx_next  = '0;
            issue_done_next = 1'b0;
            hit_found_next  = 1'b0;
            free_found_next = 1'b0;
        end
        else if (rd_en)
        begin
            rd_vld_next = 1'b1;
            if (issue_idx_reg == LAST_IDX)
            begin
                issue_done_next = 1'b1;
            end
            else
            begin
                issue_idx_next = issue_idx_reg + IDXW'(1);
            end
        end

        if (capture_hit)
        begin
            hit_found_next = 1'b1;
        end
        if (capture_free)
        begin
            free_found_next = 1'b1;
        end

        if (cmd.set_result)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg      <= '0;
            issue_idx_reg  <= '0;
            issue_done_reg <= 1'b1;
            rd_vld_reg     <= 1'b0;
            hit_found_reg  <= 1'b0;
            free_found_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            valid_reg      <= valid_next;
            issue_idx_reg  <= issue_idx_next;
            issue_done_reg <= issue_done_next;
            rd_vld_reg     <= rd_vld_next;
            hit_found_reg  <= hit_found_next;
            free_found_reg <= free_found_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            req_type_reg   <= in_tuser;
            req_ip_reg     <= in_tdata[arp_pkg::IP_W-1:0];
            req_mac_reg    <= in_tdata[arp_pkg::IP_W +: arp_pkg::MAC_W];
            req_target_reg <= in_tdata[arp_pkg::IP_W + arp_pkg::MAC_W +: arp_pkg::IP_W];
        end
        if (rd_en)
        begin
            rd_idx_reg <= issue_idx_reg;
        end
        if (capture_hit)
        begin
            hit_idx_reg <= rd_idx_reg;
            hit_mac_reg <= mac_rd_reg;
            hit_exp_reg <= exp_rd_reg;
        end
        if (capture_free)
        begin
            free_idx_reg <= rd_idx_reg;
        end
        if (cmd.set_result)
        begin
            out_code_reg <= cmd.result_code;
            out_mac_reg  <= (status.is_lookup && cmd.result_code == arp_pkg::RC_HIT)
                            ? hit_mac_reg : '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.insert)
        begin
            ip_mem[free_idx_reg] <= req_ip_reg;
        end
        if (rd_en)
        begin
            ip_rd_reg <= ip_mem[issue_idx_reg];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.insert)
        begin
            mac_mem[free_idx_reg] <= req_mac_reg;
        end
        if (rd_en)
        begin
            mac_rd_reg <= mac_mem[issue_idx_reg];
        end
    end

    always_ff @(posedge clk)
    begin
        if (exp_wr_en)
        begin
            exp_mem[exp_wr_addr] <= timeout;
        end
        if (rd_en)
        begin
            exp_rd_reg <= exp_mem[issue_idx_reg];
        end
    end

    assign out_valid = out_valid_reg;
    assign out_tdata = out_mac_reg;
    assign out_tuser = out_code_reg;

endmodule

`default_nettype wire

>>> rtl/arp_cache_table.sv
// ----------------------------------------------------------------------------
// arp_cache_table
// IPv4 to MAC address cache with lookup, merge and learning from replies.
// ----------------------------------------------------------------------------
// usage
//   s_axis carries one request item: tuser is the request kind, tdata the
//   ip, mac and target ip. m_axis returns one result item per request:
//   tuser is the result code, tdata the mac found on a lookup hit.
//   cfg writes the own ip and the two expire values; the user must make
//   them only while idle, as the block does not enforce it.
// search
//   the slot store is searched one slot per cycle through registered-read
//   memories up to the first match or the last slot; the result is then
//   registered for m_axis, and the next item is taken only back in idle.
//   A request that is ignored skips the search and has its result
//   registered from the decode step.
// reset
//   all slots are marked free at once; no clearing pass is needed.
// stalls
//   a finished result waits in the output register while the next item is
//   accepted and searched; only a second result waits for the first to go.
// ----------------------------------------------------------------------------
`default_nettype none

module arp_cache_table
#(
    parameter int ENTRIES = 16
)
(
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,

    input  wire logic                                 s_axis_tvalid,
    output logic                                      s_axis_tready,
    // ip_address [31:0], mac_address [79:32], target_ip_address [111:80]
    input  wire logic [arp_pkg::IN_TDATA_W-1:0]       s_axis_tdata,
    // req_type [1:0]
    input  wire logic [arp_pkg::REQ_W-1:0]            s_axis_tuser,

    output logic                                      m_axis_tvalid,
    input  wire logic                                 m_axis_tready,
    // found_mac_address [47:0]
    output logic [arp_pkg::OUT_TDATA_W-1:0]           m_axis_tdata,
    // result_code [2:0]
    output logic [arp_pkg::CODE_W-1:0]                m_axis_tuser,

    input  wire logic                                 cfg_valid,
    output logic                                      cfg_ready,
    input  wire logic [arp_pkg::CFG_INDEX_W-1:0]      cfg_index,
    input  wire logic [arp_pkg::CFG_DATA_W-1:0]       cfg_data
);

    arp_pkg::cfg_t    cfg_reg;
    arp_pkg::cfg_t    cfg_next;
    arp_pkg::cmd_t    cmd;
    arp_pkg::status_t status;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                arp_pkg::CFG_OWN_IP:
                    cfg_next.own_ip = cfg_data[arp_pkg::IP_W-1:0];
                arp_pkg::CFG_EXP_REPLY:
                    cfg_next.expire_on_reply = cfg_data[arp_pkg::EXP_W-1:0];
                arp_pkg::CFG_EXP_MERGE:
                    cfg_next.expire_on_merge = cfg_data[arp_pkg::EXP_W-1:0];
                default:
                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    arp_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .status   (status),
        .cmd      (cmd)
    );

    arp_dpath #(
        .ENTRIES (ENTRIES)
    ) u_dpath
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .in_tdata  (s_axis_tdata),
        .in_tuser  (s_axis_tuser),
        .cmd       (cmd),
        .status    (status),
        .out_ready (m_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_tdata (m_axis_tdata),
        .out_tuser (m_axis_tuser)
    );

    // one item at a time: busy straight after an acceptance
    assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("item accepted while previous one still in search");

    // a pending result is never overwritten
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.set_result |-> !(m_axis_tvalid && !m_axis_tready))
        else $error("result loaded over a stalled result");

    // a new slot is only claimed when the address is absent and a slot is free
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.insert |-> status.free_found && !status.hit_found)
        else $error("insert without a free slot or with a matching slot");

    // only a lookup hit carries a mac address
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tuser != arp_pkg::RC_HIT) |-> m_axis_tdata == '0)
        else $error("non-zero mac on a result other than a hit");

endmodule

`default_nettype wire

>>> sim/tb_arp_cache_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_arp_cache_table
// Self-checking bench for the address cache. A queue of requests feeds a
// stream driver; every accepted request is run through a local copy of the
// cache to predict its result item, and a monitor compares each result item
// on m_axis with the oldest prediction. Both sides idle at random but in one
// quiet phase, and the receiver holds off once for a long stretch. Four
// register settings are applied, including the extremes and a write to the
// unused index.

module tb_arp_cache_table;

    localparam int SLOTS = 16;
    localparam int POOL = 40;
    localparam int PHASE_ITEMS = 485;
    localparam int HOLD_CYCLES = 400;
    localparam logic [arp_pkg::REQ_W-1:0] REQ_UNUSED = 2'd3;
    localparam logic [arp_pkg::CFG_INDEX_W-1:0] CFG_UNUSED = 2'd3;

    typedef struct packed {
        logic [arp_pkg::REQ_W-1:0] kind;
        logic [arp_pkg::IP_W-1:0]  ip;
        logic [arp_pkg::MAC_W-1:0] mac;
        logic [arp_pkg::IP_W-1:0]  target;
    } req_item_t;

    typedef struct packed {
        arp_pkg::result_code_t     code;
        logic [arp_pkg::MAC_W-1:0] mac;
    } answer_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                            s_axis_tvalid = 1'b0;
    logic                            s_axis_tready;
    logic [arp_pkg::IN_TDATA_W-1:0]  s_axis_tdata = '0;
    logic [arp_pkg::REQ_W-1:0]       s_axis_tuser = '0;
    logic                            m_axis_tvalid;
    logic                            m_axis_tready = 1'b0;
    logic [arp_pkg::OUT_TDATA_W-1:0] m_axis_tdata;
    logic [arp_pkg::CODE_W-1:0]      m_axis_tuser;
    logic                            cfg_valid = 1'b0;
    logic                            cfg_ready;
    logic [arp_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
    logic [arp_pkg::CFG_DATA_W-1:0]  cfg_data = '0;

    // local copy of the cache and its registers
    logic                      slot_used [SLOTS];
    logic [arp_pkg::IP_W-1:0]  slot_ip [SLOTS];
    logic [arp_pkg::MAC_W-1:0] slot_mac [SLOTS];
    logic [arp_pkg::EXP_W-1:0] slot_expire [SLOTS];
    logic [arp_pkg::IP_W-1:0]  own_ip = '0;
    logic [arp_pkg::EXP_W-1:0] exp_reply = '0;
    logic [arp_pkg::EXP_W-1:0] exp_merge = '0;

    req_item_t                pending [$];
    answer_t                  answers_due [$];
    req_item_t                in_flight;
    logic [arp_pkg::IP_W-1:0] ip_pool [POOL];

    int  fails = 0;
    int  items_taken = 0;
    int  answers_seen = 0;
    int  code_count [8];
    int  gap_left = 0;
    int  stall_left = 0;
    int  hold_left = 0;
    bit  held = 1'b0;
    bit  quiet = 1'b0;

    arp_cache_table #(.ENTRIES(SLOTS)) u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    initial
    begin
        forever #10 clk = ~clk;
    end

    function automatic int slot_of(input logic [arp_pkg::IP_W-1:0] ip);
        for (int s = 0; s < SLOTS; s++)
        begin
            if (slot_used[s] && slot_ip[s] == ip)
                return s;
        end
        return -1;
    endfunction

    function automatic answer_t cache_answer(input req_item_t r);
        answer_t                   a;
        int                        s;
        logic                      learn;
        logic [arp_pkg::EXP_W-1:0] timeout;
        a.code = arp_pkg::RC_IGNORED;
        a.mac = '0;
        s = slot_of(r.ip);
        learn = (r.kind == arp_pkg::REQ_MERGE)
                || (r.kind == arp_pkg::REQ_REPLY && r.target == own_ip);
        timeout = (r.kind == arp_pkg::REQ_MERGE) ? exp_merge : exp_reply;
        if (r.kind == arp_pkg::REQ_LOOKUP)
        begin
            if (s >= 0)
            begin
                a.code = arp_pkg::RC_HIT;
                a.mac = slot_mac[s];
            end
            else
                a.code = arp_pkg::RC_MISS;
        end
        else if (learn)
        begin
            if (s >= 0)
            begin
                // refresh only ever raises the expire value
                if (slot_expire[s] < timeout)
                    slot_expire[s] = timeout;
                a.code = arp_pkg::RC_HIT;
            end
            else
            begin
                a.code = arp_pkg::RC_FULL;
                for (int f = 0; f < SLOTS; f++)
                begin
                    if (!slot_used[f] && a.code == arp_pkg::RC_FULL)
                    begin
                        slot_used[f] = 1'b1;
                        slot_ip[f] = r.ip;
                        slot_mac[f] = r.mac;
                        slot_expire[f] = timeout;
                        a.code = arp_pkg::RC_INSERTED;
                    end
                end
            end
        end
        code_count[a.code]++;
        return a;
    endfunction

    // mostly short gaps, now and then a long one
    function automatic int pick_idle();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // request driver
    always @(posedge clk)
    begin
        if (!rst_n)
            s_axis_tvalid <= 1'b0;
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                answers_due.push_back(cache_answer(in_flight));
                items_taken++;
                gap_left = quiet ? 0 : pick_idle();
            end
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (gap_left == 0 && pending.size() > 0)
                begin
                    in_flight = pending.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata <= {in_flight.target, in_flight.mac, in_flight.ip};
                    s_axis_tuser <= in_flight.kind;
                end
                else
                begin
                    if (gap_left > 0)
                        gap_left--;
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // result receiver readiness, with one long hold-off
    always @(posedge clk)
    begin
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else
        begin
            if (!held && answers_seen >= 200)
            begin
                held = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                m_axis_tready <= 1'b0;
            end
            else
            begin
                m_axis_tready <= 1'b1;
                if (!quiet && $urandom_range(0, 99) < 20)
                    stall_left = pick_idle();
            end
        end
    end

    // result checker
    always @(posedge clk)
    begin
        answer_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            answers_seen++;
            if (answers_due.size() == 0)
            begin
                $error("unexpected result item: result_code %0d found_mac_address %h",
                       m_axis_tuser, m_axis_tdata);
                fails++;
            end
            else
            begin
                want = answers_due.pop_front();
                if (m_axis_tuser !== want.code)
                begin
                    $error("result_code: expected %0d, got %0d", want.code, m_axis_tuser);
                    fails++;
                end
                if (m_axis_tdata !== want.mac)
                begin
                    $error("found_mac_address: expected %h, got %h", want.mac, m_axis_tdata);
                    fails++;
                end
            end
        end
    end

    task automatic add_req(input logic [arp_pkg::REQ_W-1:0] kind,
                           input logic [arp_pkg::IP_W-1:0] ip,
                           input logic [arp_pkg::MAC_W-1:0] mac,
                           input logic [arp_pkg::IP_W-1:0] target);
        req_item_t r;
        r.kind = kind;
        r.ip = ip;
        r.mac = mac;
        r.target = target;
        pending.push_back(r);
    endtask

    task automatic write_reg(input logic [arp_pkg::CFG_INDEX_W-1:0] idx,
                             input logic [arp_pkg::CFG_DATA_W-1:0] val);
        cfg_index <= idx;
        cfg_data <= val;
        cfg_valid <= 1'b1;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            arp_pkg::CFG_OWN_IP:    own_ip = val;
            arp_pkg::CFG_EXP_REPLY: exp_reply = val[arp_pkg::EXP_W-1:0];
            arp_pkg::CFG_EXP_MERGE: exp_merge = val[arp_pkg::EXP_W-1:0];
            default:                ;
        endcase
    endtask

    // called only with nothing in flight, aligned to the rising clock
    task automatic apply_settings(input logic [arp_pkg::CFG_DATA_W-1:0] ip_val,
                                  input logic [arp_pkg::CFG_DATA_W-1:0] reply_val,
                                  input logic [arp_pkg::CFG_DATA_W-1:0] merge_val,
                                  input bit poke_unused);
        write_reg(arp_pkg::CFG_OWN_IP, ip_val);
        if (poke_unused)
            write_reg(CFG_UNUSED, ~ip_val);
        write_reg(arp_pkg::CFG_EXP_REPLY, reply_val);
        write_reg(arp_pkg::CFG_EXP_MERGE, merge_val);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic drain();
        while (pending.size() != 0 || s_axis_tvalid || answers_due.size() != 0)
            @(posedge clk);
    endtask

    // well-formed traffic on a pool of addresses, with some noise mixed in
    task automatic queue_random(input int n);
        int                        counted;
        int                        r;
        logic [arp_pkg::REQ_W-1:0] kind;
        logic [arp_pkg::IP_W-1:0]  ip;
        logic [arp_pkg::IP_W-1:0]  target;
        counted = 0;
        while (counted < n)
        begin
            r = $urandom_range(0, 99);
            kind = (r < 40) ? arp_pkg::REQ_LOOKUP
                 : (r < 70) ? arp_pkg::REQ_MERGE
                 : (r < 96) ? arp_pkg::REQ_REPLY
                            : REQ_UNUSED;
            ip = ($urandom_range(0, 99) < 85) ? ip_pool[$urandom_range(0, POOL - 1)]
                                              : $urandom;
            target = $urandom;
            if (kind == arp_pkg::REQ_REPLY && $urandom_range(0, 99) < 80)
                target = own_ip;
            add_req(kind, ip, arp_pkg::MAC_W'({$urandom, $urandom}), target);
            if (kind != REQ_UNUSED && !(kind == arp_pkg::REQ_REPLY && target != own_ip))
                counted++;
        end
    endtask

    initial
    begin
        for (int s = 0; s < SLOTS; s++)
        begin
            slot_used[s] = 1'b0;
            slot_ip[s] = '0;
            slot_mac[s] = '0;
            slot_expire[s] = '0;
        end
        for (int c = 0; c < 8; c++)
            code_count[c] = 0;
        ip_pool[0] = '0;
        ip_pool[1] = '1;
        for (int p = 2; p < POOL; p++)
            ip_pool[p] = $urandom;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty table, extremes, ignored requests, refreshes
        apply_settings('1, 32'h0000_FFFF, '0, 1'b0);
        add_req(arp_pkg::REQ_LOOKUP, '0, '0, '0);
        add_req(arp_pkg::REQ_MERGE, '0, '0, '0);
        add_req(arp_pkg::REQ_LOOKUP, '0, '1, '1);
        add_req(arp_pkg::REQ_REPLY, '1, '1, '1);
        add_req(arp_pkg::REQ_LOOKUP, '1, '0, '0);
        add_req(arp_pkg::REQ_REPLY, 32'd1, '1, '0);
        add_req(REQ_UNUSED, 32'd1, '1, '1);
        add_req(arp_pkg::REQ_LOOKUP, 32'd1, '0, '0);
        add_req(arp_pkg::REQ_MERGE, '0, '1, '1);
        add_req(arp_pkg::REQ_LOOKUP, '0, '0, '0);
        add_req(arp_pkg::REQ_MERGE, '1, '0, '0);
        add_req(arp_pkg::REQ_LOOKUP, '1, '0, '0);
        add_req(arp_pkg::REQ_REPLY, '0, '1, '1);
        drain();

        apply_settings('0, '0, 32'hFFFF_FFFF, 1'b0);
        queue_random(PHASE_ITEMS);
        drain();

        quiet = 1'b1;
        apply_settings($urandom, $urandom, $urandom, 1'b0);
        queue_random(PHASE_ITEMS);
        drain();
        quiet = 1'b0;

        // unused index written right after own ip, must leave it alone
        apply_settings(ip_pool[2], 32'd1, 32'h0000_FFFF, 1'b1);
        queue_random(PHASE_ITEMS);
        drain();
        repeat (30) @(posedge clk);

        $display("covered %0d requests under 4 register settings, receiver held off %0d cycles",
                 items_taken, HOLD_CYCLES);
        $display("results: %0d hit, %0d miss, %0d inserted, %0d dropped full, %0d ignored",
                 code_count[arp_pkg::RC_HIT], code_count[arp_pkg::RC_MISS],
                 code_count[arp_pkg::RC_INSERTED], code_count[arp_pkg::RC_FULL],
                 code_count[arp_pkg::RC_IGNORED]);
        if (fails == 0 && answers_due.size() == 0)
            $display("tb_arp_cache_table: PASS");
        else
            $display("tb_arp_cache_table: FAIL");
        $finish;
    end

    initial
    begin
        #20_000_000;
        $display("tb_arp_cache_table: FAIL");
        $finish;
    end

endmodule

>>> arp_cache_table.f
rtl/arp_pkg.sv
rtl/arp_ctrl.sv
rtl/arp_dpath.sv
rtl/arp_cache_table.sv
sim/tb_arp_cache_table.sv
